[rtl/mpva_pkg.sv]
`default_nettype none

package mpva_pkg;

    // default pool sizes
    localparam int POOL1_VOICES_DEF = 6;
    localparam int POOL2_VOICES_DEF = 6;
    localparam int POOL3_VOICES_DEF = 9;

    // reserved mask register widths
    localparam int MASK1_W = 6;
    localparam int MASK2_W = 6;
    localparam int MASK3_W = 9;

    localparam int NUM_CNT = 5;
    localparam int CNT_W   = 8;
    localparam int NOTE_W  = 7;
    localparam int VIDX_W  = 4;

    // result action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_ON   = 2'd1;
    localparam logic [1:0] ACT_OFF  = 2'd2;

    // destination codes
    localparam logic [2:0] DEST_MIDI_MAIN = 3'd0;
    localparam logic [2:0] DEST_MIDI_ALT  = 3'd1;
    localparam logic [2:0] DEST_POOL1     = 3'd2;
    localparam logic [2:0] DEST_POOL2     = 3'd3;
    localparam logic [2:0] DEST_POOL3     = 3'd4;

    // target select codes
    localparam logic [2:0] TGT_MIDI     = 3'd0;
    localparam logic [2:0] TGT_POOL1    = 3'd1;
    localparam logic [2:0] TGT_POOL2    = 3'd2;
    localparam logic [2:0] TGT_POOL3    = 3'd3;
    localparam logic [2:0] TGT_MIDI_ALT = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_MASK1 = 2'd0;
    localparam logic [1:0] REG_MASK2 = 2'd1;
    localparam logic [1:0] REG_MASK3 = 2'd2;

    // counter slots
    localparam int CNT_MAIN  = 0;
    localparam int CNT_ALT   = 1;
    localparam int CNT_POOL1 = 2;

    typedef struct packed {
        logic              go;
        logic              is_on;
        logic              use_beat;
        logic [VIDX_W-1:0] beat_voice;
        logic [NOTE_W-1:0] note;
    } pool_cmd_t;

    typedef struct packed {
        logic              hit;
        logic [VIDX_W-1:0] voice;
    } pool_res_t;

    typedef struct packed {
        logic               go;
        logic               up;
        logic [NUM_CNT-1:0] sel;
    } cnt_cmd_t;

    typedef logic [NUM_CNT-1:0][CNT_W-1:0] cnt_vec_t;

endpackage

`default_nettype wire

[rtl/mpva_pool.sv]
`default_nettype none

module mpva_pool #(
    parameter int VOICES = mpva_pkg::POOL1_VOICES_DEF,
    parameter int MASK_W = mpva_pkg::MASK1_W
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mpva_pkg::pool_cmd_t cmd,
    input  wire logic [MASK_W-1:0]   reserved,
    output mpva_pkg::pool_res_t      res
);

    logic [mpva_pkg::NOTE_W-1:0] notes_reg [VOICES];
    logic [VOICES-1:0]           rsv;
    logic                        free_hit;
    logic [mpva_pkg::VIDX_W-1:0] free_idx;
    logic                        note_hit;
    logic [mpva_pkg::VIDX_W-1:0] note_idx;
    logic                        beat_ok;

    // voices past the mask width are never reserved
    for (genvar g = 0; g < VOICES; g++) begin : g_rsv
        if (g < MASK_W) begin : g_in
            assign rsv[g] = reserved[g];
        end else begin : g_out
            assign rsv[g] = 1'b0;
        end
    end

    // lowest-index priority search, free voice and matching note
    always_comb
    begin
        free_hit = 1'b0;
        free_idx = '0;
        note_hit = 1'b0;
        note_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!rsv[i] && notes_reg[i] == '0)
            begin
                free_hit = 1'b1;
                free_idx = mpva_pkg::VIDX_W'(i);
            end
            if (notes_reg[i] == cmd.note)
            begin
                note_hit = 1'b1;
                note_idx = mpva_pkg::VIDX_W'(i);
            end
        end
    end

    assign beat_ok = {1'b0, cmd.beat_voice} < (mpva_pkg::VIDX_W + 1)'(VOICES);

    always_comb
    begin
        if (cmd.use_beat)
        begin
            res.hit   = beat_ok;
            res.voice = cmd.beat_voice;
        end
        else if (cmd.is_on)
        begin
            res.hit   = free_hit;
            res.voice = free_idx;
        end
        else
        begin
            res.hit   = note_hit;
            res.voice = note_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                notes_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                if (cmd.go && res.hit && res.voice == mpva_pkg::VIDX_W'(i))
                begin
                    notes_reg[i] <= cmd.is_on ? cmd.note : '0;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/mpva_counters.sv]
`default_nettype none

module mpva_counters (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mpva_pkg::cnt_cmd_t cmd,
    output mpva_pkg::cnt_vec_t      cnt_next
);

    mpva_pkg::cnt_vec_t cnt_reg;

    // increment wraps, decrement holds at zero
    always_comb
    begin
        for (int k = 0; k < mpva_pkg::NUM_CNT; k++)
        begin
            cnt_next[k] = cnt_reg[k];
            if (cmd.sel[k])
            begin
                if (cmd.up)
                begin
                    cnt_next[k] = cnt_reg[k] + 1'b1;
                end
                else if (cnt_reg[k] != '0)
                begin
                    cnt_next[k] = cnt_reg[k] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.go)
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

[rtl/multi_pool_voice_allocator.sv]
`default_nettype none

// channel  dir  handshake              beat
// in       in   in_valid / in_ready    one note event
// out      out  out_valid / out_ready  one result with all five activity counters
// cfg      in   cfg_valid / cfg_ready  one reserved-mask write (cfg_index, cfg_data)
//
// one event per cycle sustained while out_ready stays high; an event passes the input
// register and then the result register; the whole voice search and state update
// is one combinational pass from the input register into the result register
// reset clears voice notes, counters, masks and both valid flags at once
// a stalled out beat holds the input register; in_ready drops only when both are full
// cfg_ready is always high

module multi_pool_voice_allocator #(
    parameter int POOL1_VOICES = mpva_pkg::POOL1_VOICES_DEF,
    parameter int POOL2_VOICES = mpva_pkg::POOL2_VOICES_DEF,
    parameter int POOL3_VOICES = mpva_pkg::POOL3_VOICES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    // event input
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       is_on,
    input  wire logic [3:0] chan_or_beat_voice,
    input  wire logic [6:0] note_num,
    input  wire logic [6:0] velocity,
    input  wire logic       want_alt,
    input  wire logic [2:0] target_sel,
    input  wire logic       beat_mode,

    // result output
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      action,
    output logic [2:0]      dest,
    output logic [3:0]      voice_index,
    output logic [3:0]      out_channel,
    output logic [6:0]      out_note,
    output logic [6:0]      out_velocity,
    output logic [7:0]      act_midi_main,
    output logic [7:0]      act_midi_alt,
    output logic [7:0]      act_pool1,
    output logic [7:0]      act_pool2,
    output logic [7:0]      act_pool3,

    // configuration writes
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [8:0] cfg_data
);

    // input register
    logic       s1_valid_reg;
    logic       s1_is_on_reg;
    logic [3:0] s1_chan_reg;
    logic [6:0] s1_note_reg;
    logic [6:0] s1_vel_reg;
    logic       s1_alt_reg;
    logic [2:0] s1_tgt_reg;
    logic       s1_beat_reg;

    // reserved masks
    logic [mpva_pkg::MASK1_W-1:0] mask1_reg;
    logic [mpva_pkg::MASK2_W-1:0] mask2_reg;
    logic [mpva_pkg::MASK3_W-1:0] mask3_reg;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         action_reg;
    logic [2:0]         dest_reg;
    logic [3:0]         voice_reg;
    logic [3:0]         chan_reg;
    logic [6:0]         note_reg;
    logic [6:0]         vel_reg;
    mpva_pkg::cnt_vec_t cnt_reg;

    logic               advance;
    logic               ignore_evt;
    logic               tgt_midi;
    logic               tgt_p1;
    logic               tgt_p2;
    logic               tgt_p3;
    mpva_pkg::pool_cmd_t cmd1;
    mpva_pkg::pool_cmd_t cmd2;
    mpva_pkg::pool_cmd_t cmd3;
    mpva_pkg::pool_res_t res1;
    mpva_pkg::pool_res_t res2;
    mpva_pkg::pool_res_t res3;
    mpva_pkg::cnt_cmd_t  ccmd;
    mpva_pkg::cnt_vec_t  cnt_next;

    logic [1:0] action_next;
    logic [2:0] dest_next;
    logic [3:0] voice_next;
    logic [3:0] chan_next;

    // the event moves on when the result register is free or being drained
    assign advance        = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !s1_valid_reg || advance;
    assign cfg_ready      = 1'b1;
    assign out_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // note-on with note zero changes no voice or counter and gives an empty result
    assign ignore_evt = s1_is_on_reg && s1_note_reg == '0;
    assign tgt_midi   = s1_tgt_reg == mpva_pkg::TGT_MIDI || s1_tgt_reg == mpva_pkg::TGT_MIDI_ALT;
    assign tgt_p1     = s1_tgt_reg == mpva_pkg::TGT_POOL1;
    assign tgt_p2     = s1_tgt_reg == mpva_pkg::TGT_POOL2;
    assign tgt_p3     = s1_tgt_reg == mpva_pkg::TGT_POOL3;

    // pool commands; beat-mode note-off only applies to pool one
    always_comb
    begin
        cmd1.go         = advance && tgt_p1 && !ignore_evt;
        cmd1.is_on      = s1_is_on_reg;
        cmd1.use_beat   = s1_beat_reg;
        cmd1.beat_voice = s1_chan_reg;
        cmd1.note       = s1_note_reg;

        cmd2.go         = advance && tgt_p2 && !ignore_evt;
        cmd2.is_on      = s1_is_on_reg;
        cmd2.use_beat   = s1_beat_reg && s1_is_on_reg;
        cmd2.beat_voice = s1_chan_reg;
        cmd2.note       = s1_note_reg;

        cmd3.go         = advance && tgt_p3 && !ignore_evt;
        cmd3.is_on      = s1_is_on_reg;
        cmd3.use_beat   = s1_beat_reg && s1_is_on_reg;
        cmd3.beat_voice = s1_chan_reg;
        cmd3.note       = s1_note_reg;
    end

    mpva_pool #(
        .VOICES (POOL1_VOICES),
        .MASK_W (mpva_pkg::MASK1_W)
    ) u_pool1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd1),
        .reserved (mask1_reg),
        .res      (res1)
    );

    mpva_pool #(
        .VOICES (POOL2_VOICES),
        .MASK_W (mpva_pkg::MASK2_W)
    ) u_pool2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd2),
        .reserved (mask2_reg),
        .res      (res2)
    );

    mpva_pool #(
        .VOICES (POOL3_VOICES),
        .MASK_W (mpva_pkg::MASK3_W)
    ) u_pool3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd3),
        .reserved (mask3_reg),
        .res      (res3)
    );

    // counter selection: midi counter follows want_alt even when alt port is forced
    always_comb
    begin
        ccmd.go  = advance;
        ccmd.up  = s1_is_on_reg;
        ccmd.sel = '0;
        if (!ignore_evt)
        begin
            if (tgt_midi)
            begin
                ccmd.sel[s1_alt_reg ? mpva_pkg::CNT_ALT : mpva_pkg::CNT_MAIN] = 1'b1;
            end
            if (tgt_p1)
            begin
                ccmd.sel[mpva_pkg::CNT_POOL1] = 1'b1;
            end
            if (tgt_p2)
            begin
                ccmd.sel[mpva_pkg::CNT_POOL1 + 1] = 1'b1;
            end
            if (tgt_p3)
            begin
                ccmd.sel[mpva_pkg::CNT_POOL1 + 2] = 1'b1;
            end
        end
    end

    mpva_counters u_cnt (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (ccmd),
        .cnt_next (cnt_next)
    );

    // result fields
    always_comb
    begin
        action_next = mpva_pkg::ACT_NONE;
        dest_next   = mpva_pkg::DEST_MIDI_MAIN;
        voice_next  = '0;
        chan_next   = '0;
        if (!ignore_evt)
        begin
            if (tgt_midi)
            begin
                action_next = s1_is_on_reg ? mpva_pkg::ACT_ON : mpva_pkg::ACT_OFF;
                dest_next   = (s1_alt_reg || s1_tgt_reg == mpva_pkg::TGT_MIDI_ALT)
                              ? mpva_pkg::DEST_MIDI_ALT : mpva_pkg::DEST_MIDI_MAIN;
                voice_next  = s1_chan_reg;
                chan_next   = s1_chan_reg;
            end
            else if ((tgt_p1 && res1.hit) || (tgt_p2 && res2.hit) || (tgt_p3 && res3.hit))
            begin
                action_next = s1_is_on_reg ? mpva_pkg::ACT_ON : mpva_pkg::ACT_OFF;
                if (tgt_p1)
                begin
                    dest_next  = mpva_pkg::DEST_POOL1;
                    voice_next = res1.voice;
                end
                else if (tgt_p2)
                begin
                    dest_next  = mpva_pkg::DEST_POOL2;
                    voice_next = res2.voice;
                end
                else
                begin
                    dest_next  = mpva_pkg::DEST_POOL3;
                    voice_next = res3.voice;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask1_reg     <= '0;
            mask2_reg     <= '0;
            mask3_reg     <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    mpva_pkg::REG_MASK1: mask1_reg <= cfg_data[mpva_pkg::MASK1_W-1:0];
                    mpva_pkg::REG_MASK2: mask2_reg <= cfg_data[mpva_pkg::MASK2_W-1:0];
                    mpva_pkg::REG_MASK3: mask3_reg <= cfg_data[mpva_pkg::MASK3_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_is_on_reg <= is_on;
            s1_chan_reg  <= chan_or_beat_voice;
            s1_note_reg  <= note_num;
            s1_vel_reg   <= velocity;
            s1_alt_reg   <= want_alt;
            s1_tgt_reg   <= target_sel;
            s1_beat_reg  <= beat_mode;
        end
        if (advance)
        begin
            action_reg <= action_next;
            dest_reg   <= dest_next;
            voice_reg  <= voice_next;
            chan_reg   <= chan_next;
            note_reg   <= (action_next == mpva_pkg::ACT_NONE) ? '0 : s1_note_reg;
            vel_reg    <= (action_next == mpva_pkg::ACT_NONE) ? '0 : s1_vel_reg;
            cnt_reg    <= cnt_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign action        = action_reg;
    assign dest          = dest_reg;
    assign voice_index   = voice_reg;
    assign out_channel   = chan_reg;
    assign out_note      = note_reg;
    assign out_velocity  = vel_reg;
    assign act_midi_main = cnt_reg[mpva_pkg::CNT_MAIN];
    assign act_midi_alt  = cnt_reg[mpva_pkg::CNT_ALT];
    assign act_pool1     = cnt_reg[mpva_pkg::CNT_POOL1];
    assign act_pool2     = cnt_reg[mpva_pkg::CNT_POOL1 + 1];
    assign act_pool3     = cnt_reg[mpva_pkg::CNT_POOL1 + 2];

endmodule

`default_nettype wire

[rtl/mpva_checker.sv]
`default_nettype none

module mpva_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] action,
    input wire logic [2:0] dest,
    input wire logic [3:0] voice_index,
    input wire logic [3:0] out_channel,
    input wire logic [6:0] out_note,
    input wire logic [7:0] act_pool1
);

    // stalled beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action) && $stable(dest)
            && $stable(voice_index) && $stable(out_note) && $stable(act_pool1))
        else $error("stalled result changed");

    // empty result carries zeros
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == mpva_pkg::ACT_NONE |-> dest == '0 && voice_index == '0
            && out_channel == '0 && out_note == '0)
        else $error("empty result has nonzero fields");

    // pools carry no channel
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != mpva_pkg::ACT_NONE && (dest == mpva_pkg::DEST_POOL1
            || dest == mpva_pkg::DEST_POOL2 || dest == mpva_pkg::DEST_POOL3)
            |-> out_channel == '0)
        else $error("pool result carries a channel");

    // a note-on that was emitted never has note zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == mpva_pkg::ACT_ON |-> out_note != '0)
        else $error("note-on with note zero emitted");

endmodule

bind multi_pool_voice_allocator mpva_checker u_mpva_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .action      (action),
    .dest        (dest),
    .voice_index (voice_index),
    .out_channel (out_channel),
    .out_note    (out_note),
    .act_pool1   (act_pool1)
);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int PHASES          = 5;
    localparam int EVENTS_PER_PHASE = 140;
    localparam int WRAP_BURST      = 260;
    localparam int TAIL_CYCLES     = 8;

    // one note event as it goes into the block
    typedef struct packed {
        logic       is_on;
        logic [3:0] chan;
        logic [6:0] note;
        logic [6:0] vel;
        logic       alt;
        logic [2:0] tgt;
        logic       beat;
    } note_event_t;

    // one result beat, counters in the order main, alt, pool one, two, three
    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         dest;
        logic [3:0]         voice;
        logic [3:0]         chan;
        logic [6:0]         note;
        logic [6:0]         vel;
        mpva_pkg::cnt_vec_t counts;
    } voice_result_t;

    // a note the stimulus believes is sounding, kept for matching note-offs
    typedef struct packed {
        logic [2:0] tgt;
        logic [6:0] note;
    } sounding_t;

    // voice allocation predictor and result store
    class voice_scoreboard;
        logic [6:0]         voices[3][16];
        logic [15:0]        masks[3];
        int                 sizes[3];
        mpva_pkg::cnt_vec_t counts;
        voice_result_t      pending_results[$];
        int                 n_errors;
        int                 n_events;
        int                 n_results;

        function new();
            sizes = '{mpva_pkg::POOL1_VOICES_DEF, mpva_pkg::POOL2_VOICES_DEF,
                      mpva_pkg::POOL3_VOICES_DEF};
            foreach (voices[p, v]) voices[p][v] = '0;
            foreach (masks[p]) masks[p] = '0;
            counts    = '0;
            n_errors  = 0;
            n_events  = 0;
            n_results = 0;
        endfunction

        function void set_mask(logic [1:0] idx, logic [8:0] value);
            case (idx)
                mpva_pkg::REG_MASK1: masks[0] = 16'(value[mpva_pkg::MASK1_W-1:0]);
                mpva_pkg::REG_MASK2: masks[1] = 16'(value[mpva_pkg::MASK2_W-1:0]);
                mpva_pkg::REG_MASK3: masks[2] = 16'(value[mpva_pkg::MASK3_W-1:0]);
                default: ;
            endcase
        endfunction

        function void bump(int slot, logic up);
            if (up)
                counts[slot] = counts[slot] + 8'd1;
            else if (counts[slot] != '0)
                counts[slot] = counts[slot] - 8'd1;
        endfunction

        function int first_free(int p);
            for (int i = 0; i < sizes[p]; i++)
                if (!masks[p][i] && voices[p][i] == '0)
                    return i;
            return -1;
        endfunction

        function int first_holding(int p, logic [6:0] note);
            for (int i = 0; i < sizes[p]; i++)
                if (voices[p][i] == note)
                    return i;
            return -1;
        endfunction

        function int beat_voice(int p, logic [3:0] chan);
            return (int'(chan) < sizes[p]) ? int'(chan) : -1;
        endfunction

        // predicts the result of one accepted event and updates the voice state
        function void note_event(note_event_t ev);
            voice_result_t r;
            int            p;
            int            v;
            r = '0;
            v = -1;
            n_events++;
            if (!(ev.is_on && ev.note == '0)) begin
                if (ev.tgt == mpva_pkg::TGT_MIDI || ev.tgt == mpva_pkg::TGT_MIDI_ALT) begin
                    r.action = ev.is_on ? mpva_pkg::ACT_ON : mpva_pkg::ACT_OFF;
                    r.dest   = (ev.tgt == mpva_pkg::TGT_MIDI_ALT || ev.alt)
                               ? mpva_pkg::DEST_MIDI_ALT : mpva_pkg::DEST_MIDI_MAIN;
                    r.voice  = ev.chan;
                    r.chan   = ev.chan;
                    bump(ev.alt ? mpva_pkg::CNT_ALT : mpva_pkg::CNT_MAIN, ev.is_on);
                end
                else if (ev.tgt >= mpva_pkg::TGT_POOL1 && ev.tgt <= mpva_pkg::TGT_POOL3) begin
                    p = int'(ev.tgt - mpva_pkg::TGT_POOL1);
                    if (ev.is_on) begin
                        v = ev.beat ? beat_voice(p, ev.chan) : first_free(p);
                        if (v >= 0) begin
                            voices[p][v] = ev.note;
                            r.action = mpva_pkg::ACT_ON;
                        end
                    end
                    else begin
                        v = (ev.beat && p == 0) ? beat_voice(p, ev.chan)
                                                : first_holding(p, ev.note);
                        if (v >= 0) begin
                            voices[p][v] = '0;
                            r.action = mpva_pkg::ACT_OFF;
                        end
                    end
                    bump(mpva_pkg::CNT_POOL1 + p, ev.is_on);
                    if (r.action != mpva_pkg::ACT_NONE) begin
                        r.dest  = 3'(mpva_pkg::DEST_POOL1 + p);
                        r.voice = v[3:0];
                    end
                end
            end
            if (r.action != mpva_pkg::ACT_NONE) begin
                r.note = ev.note;
                r.vel  = ev.vel;
            end
            r.counts = counts;
            pending_results.push_back(r);
        endfunction

        task report_mismatch(input string msg);
            n_errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(input voice_result_t got);
            voice_result_t want;
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending");
                return;
            end
            want = pending_results.pop_front();
            n_results++;
            if (got.action !== want.action)
                report_mismatch($sformatf("action %0d, want %0d", got.action, want.action));
            if (got.dest !== want.dest)
                report_mismatch($sformatf("dest %0d, want %0d", got.dest, want.dest));
            if (got.voice !== want.voice)
                report_mismatch($sformatf("voice_index %0d, want %0d", got.voice, want.voice));
            if (got.chan !== want.chan)
                report_mismatch($sformatf("out_channel %0d, want %0d", got.chan, want.chan));
            if (got.note !== want.note)
                report_mismatch($sformatf("out_note %0d, want %0d", got.note, want.note));
            if (got.vel !== want.vel)
                report_mismatch($sformatf("out_velocity %0d, want %0d", got.vel, want.vel));
            for (int k = 0; k < mpva_pkg::NUM_CNT; k++)
                if (got.counts[k] !== want.counts[k])
                    report_mismatch($sformatf("counter %0d is %0d, want %0d",
                                              k, got.counts[k], want.counts[k]));
        endtask
    endclass

    // clock, reset and every block input start at known values
    logic       clk                = 1'b0;
    logic       rst_n              = 1'b0;
    logic       in_valid           = 1'b0;
    logic       in_ready;
    logic       is_on              = 1'b0;
    logic [3:0] chan_or_beat_voice = '0;
    logic [6:0] note_num           = '0;
    logic [6:0] velocity           = '0;
    logic       want_alt           = 1'b0;
    logic [2:0] target_sel         = '0;
    logic       beat_mode          = 1'b0;
    logic       out_valid;
    logic       out_ready          = 1'b0;
    logic [1:0] action;
    logic [2:0] dest;
    logic [3:0] voice_index;
    logic [3:0] out_channel;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic [7:0] act_midi_main;
    logic [7:0] act_midi_alt;
    logic [7:0] act_pool1;
    logic [7:0] act_pool2;
    logic [7:0] act_pool3;
    logic       cfg_valid          = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index          = '0;
    logic [8:0] cfg_data           = '0;

    voice_scoreboard sb;
    sounding_t       sounding_q[$];
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              cycle_count    = 0;

    multi_pool_voice_allocator dut (.*);

    always #2 clk = ~clk;

    // hard stop in case the block hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: check the beat taken at this edge, then pick next ready
    always @(posedge clk) begin
        voice_result_t seen;
        if (rst_n && out_valid && out_ready) begin
            seen.action = action;
            seen.dest   = dest;
            seen.voice  = voice_index;
            seen.chan   = out_channel;
            seen.note   = out_note;
            seen.vel    = out_velocity;
            seen.counts = {act_pool3, act_pool2, act_pool1, act_midi_alt, act_midi_main};
            sb.check_result(seen);
        end
        out_ready <= (rst_n && $urandom_range(99) >= recv_stall_pct);
    end

    function automatic note_event_t make_event(logic on, logic [3:0] chan, logic [6:0] note,
                                               logic [6:0] vel, logic alt, logic [2:0] tgt,
                                               logic beat);
        note_event_t ev;
        ev.is_on = on;
        ev.chan  = chan;
        ev.note  = note;
        ev.vel   = vel;
        ev.alt   = alt;
        ev.tgt   = tgt;
        ev.beat  = beat;
        return ev;
    endfunction

    // mostly matched on/off pairs into the pools, some MIDI, some pure noise
    function automatic note_event_t random_event();
        note_event_t ev;
        sounding_t   s;
        int          roll;
        int          idx;
        ev.chan = 4'($urandom_range(15));
        ev.vel  = 7'($urandom_range(127));
        ev.alt  = 1'($urandom_range(1));
        ev.beat = ($urandom_range(99) < 20);
        roll    = $urandom_range(99);
        if (roll < 40 && sounding_q.size() != 0) begin
            // release something that was played earlier
            idx = $urandom_range(sounding_q.size() - 1);
            s = sounding_q[idx];
            sounding_q.delete(idx);
            ev.is_on = 1'b0;
            ev.tgt   = s.tgt;
            ev.note  = s.note;
        end
        else if (roll < 75) begin
            ev.is_on = 1'b1;
            ev.tgt   = 3'(mpva_pkg::TGT_POOL1 + $urandom_range(2));
            ev.note  = 7'($urandom_range(127, 1));
            s.tgt    = ev.tgt;
            s.note   = ev.note;
            if (sounding_q.size() < 48)
                sounding_q.push_back(s);
        end
        else if (roll < 90) begin
            ev.is_on = 1'b1;
            ev.is_on = 1'($urandom_range(1));
            ev.tgt   = $urandom_range(1) ? mpva_pkg::TGT_MIDI_ALT : mpva_pkg::TGT_MIDI;
            ev.note  = 7'($urandom_range(127));
        end
        else begin
            ev.is_on = 1'($urandom_range(1));
            ev.tgt   = 3'($urandom_range(7));
            ev.note  = 7'($urandom_range(127));
        end
        return ev;
    endfunction

    // hold the beat until taken; valid stays up if the next beat follows at once
    task automatic send_event(input note_event_t ev);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid           <= 1'b1;
        is_on              <= ev.is_on;
        chan_or_beat_voice <= ev.chan;
        note_num           <= ev.note;
        velocity           <= ev.vel;
        want_alt           <= ev.alt;
        target_sel         <= ev.tgt;
        beat_mode          <= ev.beat;
        do @(posedge clk); while (!in_ready);
        sb.note_event(ev);
    endtask

    // three back-to-back register writes
    task automatic write_masks(input logic [8:0] m1, input logic [8:0] m2,
                               input logic [8:0] m3);
        logic [8:0] vals[3];
        logic [1:0] regs[3];
        vals = '{m1, m2, m3};
        regs = '{mpva_pkg::REG_MASK1, mpva_pkg::REG_MASK2, mpva_pkg::REG_MASK3};
        for (int i = 0; i < 3; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.set_mask(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, masks still at reset, no idling
        // note-off on an idle counter must stay at zero
        send_event(make_event(1'b0, 4'd0,  7'd0,   7'd0,   1'b0, mpva_pkg::TGT_MIDI,     1'b0));
        send_event(make_event(1'b1, 4'd15, 7'd127, 7'd127, 1'b0, mpva_pkg::TGT_MIDI,     1'b0));
        send_event(make_event(1'b1, 4'd5,  7'd64,  7'd1,   1'b1, mpva_pkg::TGT_MIDI,     1'b0));
        // forced alternate port, counter still follows want_alt
        send_event(make_event(1'b1, 4'd10, 7'd33,  7'd90,  1'b0, mpva_pkg::TGT_MIDI_ALT, 1'b0));
        send_event(make_event(1'b0, 4'd10, 7'd33,  7'd0,   1'b1, mpva_pkg::TGT_MIDI_ALT, 1'b1));
        // note-on with note zero is dropped
        send_event(make_event(1'b1, 4'd3,  7'd0,   7'd99,  1'b0, mpva_pkg::TGT_POOL1,    1'b0));
        send_event(make_event(1'b1, 4'd3,  7'd0,   7'd99,  1'b1, mpva_pkg::TGT_MIDI,     1'b0));
        // first-free search and note match in pool one
        send_event(make_event(1'b1, 4'd0,  7'd60,  7'd100, 1'b0, mpva_pkg::TGT_POOL1,    1'b0));
        send_event(make_event(1'b1, 4'd0,  7'd61,  7'd101, 1'b0, mpva_pkg::TGT_POOL1,    1'b0));
        send_event(make_event(1'b0, 4'd0,  7'd60,  7'd20,  1'b0, mpva_pkg::TGT_POOL1,    1'b0));
        // beat index in range and just past the pool
        send_event(make_event(1'b1, 4'd5,  7'd70,  7'd50,  1'b0, mpva_pkg::TGT_POOL1,    1'b1));
        send_event(make_event(1'b1, 4'd6,  7'd71,  7'd50,  1'b0, mpva_pkg::TGT_POOL1,    1'b1));
        // beat note-off in pool one frees by index
        send_event(make_event(1'b0, 4'd5,  7'd1,   7'd50,  1'b0, mpva_pkg::TGT_POOL1,    1'b1));
        send_event(make_event(1'b0, 4'd15, 7'd61,  7'd50,  1'b0, mpva_pkg::TGT_POOL1,    1'b1));
        // pool two ignores beat mode on note-off
        send_event(make_event(1'b1, 4'd3,  7'd40,  7'd77,  1'b0, mpva_pkg::TGT_POOL2,    1'b1));
        send_event(make_event(1'b0, 4'd0,  7'd40,  7'd77,  1'b0, mpva_pkg::TGT_POOL2,    1'b1));
        // last voice of pool three and one past it
        send_event(make_event(1'b1, 4'd8,  7'd100, 7'd5,   1'b1, mpva_pkg::TGT_POOL3,    1'b1));
        send_event(make_event(1'b1, 4'd9,  7'd101, 7'd5,   1'b1, mpva_pkg::TGT_POOL3,    1'b1));
        send_event(make_event(1'b0, 4'd8,  7'd100, 7'd5,   1'b0, mpva_pkg::TGT_POOL3,    1'b1));
        // note-off with note zero hits the lowest free voice
        send_event(make_event(1'b0, 4'd0,  7'd0,   7'd0,   1'b0, mpva_pkg::TGT_POOL2,    1'b0));
        // note-off for a note nobody holds
        send_event(make_event(1'b0, 4'd0,  7'd99,  7'd3,   1'b0, mpva_pkg::TGT_POOL3,    1'b0));
        // no target at all
        send_event(make_event(1'b1, 4'd1,  7'd12,  7'd12,  1'b0, 3'd5,         1'b0));
        send_event(make_event(1'b0, 4'd2,  7'd13,  7'd13,  1'b1, 3'd6,         1'b1));
        send_event(make_event(1'b1, 4'd4,  7'd14,  7'd14,  1'b1, 3'd7,         1'b0));
        drain();

        // random phases; the idling pattern follows the phase modulo four, masks cleared, then all set, then random
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (ph == 0)
                write_masks('0, '0, '0);
            else if (ph == 1)
                write_masks('1, '1, '1);
            else
                write_masks(9'($urandom_range(511)), 9'($urandom_range(511)),
                            9'($urandom_range(511)));

            // a long run of note-ons on one port walks its counter past 255
            if (ph == 2)
                for (int i = 0; i < WRAP_BURST; i++)
                    send_event(make_event(1'b1, 4'($urandom_range(15)),
                                          7'($urandom_range(127, 1)),
                                          7'($urandom_range(127)), 1'b1,
                                          $urandom_range(1) ? mpva_pkg::TGT_MIDI_ALT
                                                            : mpva_pkg::TGT_MIDI,
                                          1'($urandom_range(1))));

            for (int i = 0; i < EVENTS_PER_PHASE; i++)
                send_event(random_event());
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d note events sent, %0d result beats checked", sb.n_events, sb.n_results);
        $display("covered MIDI routing, three pools, beat mode, masks and counter limits");
        if (sb.n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
rtl/mpva_pkg.sv
rtl/mpva_pool.sv
rtl/mpva_counters.sv
rtl/multi_pool_voice_allocator.sv
rtl/mpva_checker.sv
tb/tb.sv
